// ===== src/ipc_pkg.sv =====
// ipc_pkg: shared types and constants for the interval probability combiner
`default_nettype none

package ipc_pkg;

    // fixed point format: ONE_FX stands for probability 1.0
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned VAL_W     = FRAC_BITS + 1;
    localparam logic [VAL_W-1:0] ONE_FX  = VAL_W'(1) << FRAC_BITS;
    localparam logic [VAL_W-1:0] ZERO_FX = '0;

    // combinator selection
    typedef enum logic [2:0] {
        MODE_DEP_CONJ = 3'd0,
        MODE_DEP_DISJ = 3'd1,
        MODE_POS_CONJ = 3'd2,
        MODE_POS_DISJ = 3'd3,
        MODE_NEG_CONJ = 3'd4,
        MODE_NEG_DISJ = 3'd5,
        MODE_IND_CONJ = 3'd6,
        MODE_IND_DISJ = 3'd7
    } ipc_mode_t;

    // operation applied to one pair of bounds
    typedef enum logic [2:0] {
        OP_MAX      = 3'd0,
        OP_MIN      = 3'd1,
        OP_SAT_ADD  = 3'd2,
        OP_FRECHET  = 3'd3,
        OP_MUL      = 3'd4,
        OP_NOISY_OR = 3'd5
    } ipc_op_t;

    // input request
    typedef struct packed {
        ipc_mode_t        mode;
        logic [VAL_W-1:0] left_low;
        logic [VAL_W-1:0] left_high;
        logic [VAL_W-1:0] right_low;
        logic [VAL_W-1:0] right_high;
    } ipc_in_t;

    // combined interval
    typedef struct packed {
        logic [VAL_W-1:0] result_low;
        logic [VAL_W-1:0] result_high;
    } ipc_out_t;

endpackage

`default_nettype wire

// ===== src/interval_probability_combiner.sv =====
// interval_probability_combiner: combines two probability intervals in one registered pass
//
//   channel   direction  handshake                 payload
//   item      in         item_valid / item_stall   ipc_in_t  (mode, two intervals)
//   result    out        result_valid/result_stall ipc_out_t (combined interval)
//
// A request passes from an input register through one
// multiplier per bound with its min/max/add logic, then to the result register.
// One request is taken every cycle while the result side keeps draining.
// Reset clears only the two stage valid flags; payload registers keep no reset.
// A stall on the result side holds the result register and, once the input
// register is also full, raises item_stall in the same cycle.
`default_nettype none

module interval_probability_combiner (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire ipc_pkg::ipc_in_t item,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output ipc_pkg::ipc_out_t    result
);
    import ipc_pkg::*;

    // saturate a bound to one
    function automatic logic [VAL_W-1:0] sat_in(input logic [VAL_W-1:0] v);
        return (v > ONE_FX) ? ONE_FX : v;
    endfunction

    // combine one pair of bounds; one multiplier per call
    function automatic logic [VAL_W-1:0] combine(
        input ipc_op_t          op,
        input logic [VAL_W-1:0] a,
        input logic [VAL_W-1:0] b
    );
        logic [VAL_W:0]       sum;
        logic [VAL_W-1:0]     ma;
        logic [VAL_W-1:0]     mb;
        logic [2*VAL_W-1:0]   prod;
        logic [VAL_W-1:0]     pq;
        logic [VAL_W-1:0]     res;
        sum = {1'b0, a} + {1'b0, b};
        // noisy-or multiplies the complements
        ma = (op == OP_NOISY_OR) ? (ONE_FX - a) : a;
        mb = (op == OP_NOISY_OR) ? (ONE_FX - b) : b;
        prod = {{VAL_W{1'b0}}, ma} * {{VAL_W{1'b0}}, mb};
        pq = prod[FRAC_BITS +: VAL_W];
        case (op)
            OP_MAX:      res = (a > b) ? a : b;
            OP_MIN:      res = (a < b) ? a : b;
            OP_SAT_ADD:  res = (sum > {1'b0, ONE_FX}) ? ONE_FX : sum[VAL_W-1:0];
            OP_FRECHET:  res = (sum > {1'b0, ONE_FX}) ?
                               VAL_W'(sum - {1'b0, ONE_FX}) : ZERO_FX;
            OP_MUL:      res = pq;
            OP_NOISY_OR: res = ONE_FX - pq;
            default:     res = ZERO_FX;
        endcase
        return res;
    endfunction

    ipc_in_t  in_reg;
    logic     in_valid_reg;
    ipc_out_t out_reg;
    logic     out_valid_reg;

    logic     out_free;
    logic     in_free;
    ipc_op_t  op_low;
    ipc_op_t  op_high;
    ipc_out_t out_next;

    // stage flow control
    assign out_free   = !out_valid_reg || !result_stall;
    assign in_free    = !in_valid_reg || out_free;
    assign item_stall = !in_free;

    // mode decoder: operation per bound
    always_comb
    begin
        unique case (in_reg.mode)
            MODE_DEP_CONJ:
            begin
                op_low  = OP_FRECHET;
                op_high = OP_MIN;
            end
            MODE_DEP_DISJ:
            begin
                op_low  = OP_MAX;
                op_high = OP_SAT_ADD;
            end
            MODE_POS_CONJ:
            begin
                op_low  = OP_MUL;
                op_high = OP_MIN;
            end
            MODE_POS_DISJ:
            begin
                op_low  = OP_MAX;
                op_high = OP_NOISY_OR;
            end
            MODE_NEG_CONJ:
            begin
                op_low  = OP_FRECHET;
                op_high = OP_MUL;
            end
            MODE_NEG_DISJ:
            begin
                op_low  = OP_NOISY_OR;
                op_high = OP_SAT_ADD;
            end
            MODE_IND_CONJ:
            begin
                op_low  = OP_MUL;
                op_high = OP_MUL;
            end
            MODE_IND_DISJ:
            begin
                op_low  = OP_NOISY_OR;
                op_high = OP_NOISY_OR;
            end
            default:
            begin
                op_low  = OP_MAX;
                op_high = OP_MAX;
            end
        endcase
    end

    // bound arithmetic
    always_comb
    begin
        out_next.result_low  = combine(op_low,  sat_in(in_reg.left_low),
                                                sat_in(in_reg.right_low));
        out_next.result_high = combine(op_high, sat_in(in_reg.left_high),
                                                sat_in(in_reg.right_high));
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_free)
                in_valid_reg <= item_valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_free && item_valid)
            in_reg <= item;
        if (out_free && in_valid_reg)
            out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// tb: self-checking testbench for the interval probability combiner
`timescale 1ns / 100ps

module tb;

    import ipc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned PHASE_ITEMS = 215;
    localparam logic [63:0] UNITY = 64'(ONE_FX);
    localparam logic [VAL_W-1:0] FIELD_MAX = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    ipc_in_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    ipc_out_t result;

    // stimulus and scoreboard state
    ipc_in_t pending_reqs[$];
    ipc_out_t expected_intervals[$];
    logic req_taken = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned req_count = 0;
    int unsigned results_checked = 0;
    int unsigned fail_count = 0;
    logic [7:0] modes_seen = '0;

    // idling controls, set per phase
    int unsigned gap_max = 0;
    int unsigned stall_max = 0;
    int unsigned hold_trigger = 0;

    interval_probability_combiner u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    // bound saturation to 1.0
    function automatic logic [63:0] clamp_unity(logic [63:0] v);
        return (v > UNITY) ? UNITY : v;
    endfunction

    // truncated fixed point product
    function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b);
        return (a * b) >> FRAC_BITS;
    endfunction

    function automatic logic [63:0] capped_sum(logic [63:0] a, logic [63:0] b);
        return (a + b > UNITY) ? UNITY : a + b;
    endfunction

    function automatic logic [63:0] frechet_floor(logic [63:0] a, logic [63:0] b);
        return (a + b > UNITY) ? a + b - UNITY : 64'd0;
    endfunction

    function automatic logic [63:0] noisy_or(logic [63:0] a, logic [63:0] b);
        return UNITY - scaled_product(UNITY - a, UNITY - b);
    endfunction

    function automatic logic [63:0] larger(logic [63:0] a, logic [63:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [63:0] smaller(logic [63:0] a, logic [63:0] b);
        return (a < b) ? a : b;
    endfunction

    // combined interval for one request
    function automatic ipc_out_t combine_interval(ipc_in_t req);
        logic [63:0] al;
        logic [63:0] ah;
        logic [63:0] bl;
        logic [63:0] bh;
        logic [63:0] lo;
        logic [63:0] hi;
        ipc_out_t res;
        al = clamp_unity(64'(req.left_low));
        ah = clamp_unity(64'(req.left_high));
        bl = clamp_unity(64'(req.right_low));
        bh = clamp_unity(64'(req.right_high));
        case (req.mode)
            MODE_DEP_CONJ:
            begin
                lo = frechet_floor(al, bl);
                hi = smaller(ah, bh);
            end
            MODE_DEP_DISJ:
            begin
                lo = larger(al, bl);
                hi = capped_sum(ah, bh);
            end
            MODE_POS_CONJ:
            begin
                lo = scaled_product(al, bl);
                hi = smaller(ah, bh);
            end
            MODE_POS_DISJ:
            begin
                lo = larger(al, bl);
                hi = noisy_or(ah, bh);
            end
            MODE_NEG_CONJ:
            begin
                lo = frechet_floor(al, bl);
                hi = scaled_product(ah, bh);
            end
            MODE_NEG_DISJ:
            begin
                lo = noisy_or(al, bl);
                hi = capped_sum(ah, bh);
            end
            MODE_IND_CONJ:
            begin
                lo = scaled_product(al, bl);
                hi = scaled_product(ah, bh);
            end
            default:
            begin
                lo = noisy_or(al, bl);
                hi = noisy_or(ah, bh);
            end
        endcase
        res.result_low  = lo[VAL_W-1:0];
        res.result_high = hi[VAL_W-1:0];
        return res;
    endfunction

    // bound value biased toward the edges of the range
    function automatic logic [VAL_W-1:0] random_bound();
        case ($urandom_range(0, 9))
            0: return ZERO_FX;
            1: return ONE_FX;
            2: return ONE_FX - 1'b1;
            3: return VAL_W'($urandom_range(int'(ONE_FX) + 1, int'(FIELD_MAX)));
            default: return VAL_W'($urandom_range(0, int'(ONE_FX)));
        endcase
    endfunction

    // request sender: bursts of random length separated by random gaps
    always @(negedge clk)
    begin : req_driver
        logic nxt_valid;
        ipc_in_t nxt_item;
        int unsigned burst_left;
        int unsigned gap_left;
        nxt_valid = item_valid;
        nxt_item  = item;
        if (rst_n && !(item_valid && !req_taken))
        begin
            nxt_valid = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_reqs.size() > 0)
            begin
                nxt_item  = pending_reqs.pop_front();
                nxt_valid = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 12);
                    gap_left   = $urandom_range(0, gap_max);
                end
            end
        end
        item_valid <= nxt_valid;
        item       <= nxt_item;
    end

    // result receiver: stall pattern of its own plus long hold-offs on demand
    always @(negedge clk)
    begin : result_receiver
        int unsigned hold_seen;
        int unsigned hold_left;
        int unsigned run_left;
        logic stall_on;
        if (hold_seen != hold_trigger)
        begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            if (run_left > 0)
                run_left--;
            else
            begin
                stall_on = !stall_on && (stall_max != 0);
                run_left = stall_on ? $urandom_range(0, stall_max) : $urandom_range(0, 10);
            end
            result_stall <= stall_on;
        end
    end

    // handshake sampling, result checking and the cycle limit
    always @(posedge clk)
    begin : result_monitor
        ipc_out_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            req_taken <= rst_n && item_valid && !item_stall;
            if (rst_n)
            begin
                if (result_valid && !result_stall)
                begin
                    results_checked++;
                    if (expected_intervals.size() == 0)
                    begin
                        $error("result with no request outstanding: low %0d high %0d",
                               result.result_low, result.result_high);
                        fail_count++;
                    end
                    else
                    begin
                        want = expected_intervals.pop_front();
                        if (result.result_low !== want.result_low)
                        begin
                            $error("result_low: expected %0d, actual %0d",
                                   want.result_low, result.result_low);
                            fail_count++;
                        end
                        if (result.result_high !== want.result_high)
                        begin
                            $error("result_high: expected %0d, actual %0d",
                                   want.result_high, result.result_high);
                            fail_count++;
                        end
                    end
                end
                if (item_valid && !item_stall)
                begin
                    expected_intervals = {expected_intervals, combine_interval(item)};
                    req_count++;
                    modes_seen[item.mode] = 1'b1;
                end
            end
        end
    end

    task automatic queue_request(ipc_mode_t m, logic [VAL_W-1:0] ll, logic [VAL_W-1:0] lh,
                                 logic [VAL_W-1:0] rl, logic [VAL_W-1:0] rh);
        ipc_in_t req;
        req.mode       = m;
        req.left_low   = ll;
        req.left_high  = lh;
        req.right_low  = rl;
        req.right_high = rh;
        pending_reqs = {pending_reqs, req};
    endtask

    task automatic queue_random(int unsigned count);
        repeat (count)
            queue_request(ipc_mode_t'($urandom_range(0, 7)), random_bound(), random_bound(),
                          random_bound(), random_bound());
    endtask

    // waits until every request is sent and every result is back
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || item_valid || expected_intervals.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        ipc_mode_t m;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // directed: every mode with full range, inputs above one, inverted intervals
        for (int i = 0; i < 8; i++)
        begin
            m = ipc_mode_t'(i);
            queue_request(m, ZERO_FX, ONE_FX, ZERO_FX, ONE_FX);
            queue_request(m, FIELD_MAX, ONE_FX + 1'b1, 17'h18000, ONE_FX);
            queue_request(m, 17'h0C000, 17'h04000, 17'h08000, 17'h00001);
        end
        wait_drained();

        // random phases with varying idling on both sides
        gap_max = 0;
        stall_max = 0;
        queue_random(PHASE_ITEMS);
        wait_drained();

        gap_max = 4;
        stall_max = 4;
        queue_random(PHASE_ITEMS);
        wait_drained();

        gap_max = 8;
        stall_max = 2;
        queue_random(PHASE_ITEMS);
        wait_drained();

        // back-pressure: receiver holds off while the sender keeps offering
        gap_max = 0;
        stall_max = 8;
        queue_random(PHASE_ITEMS);
        hold_trigger++;
        wait_drained();

        gap_max = 2;
        stall_max = 3;
        queue_random(PHASE_ITEMS);
        hold_trigger++;
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d requests over mode mask %b, %0d results checked",
                 req_count, modes_seen, results_checked);
        $display("%0d mismatches, %0d results outstanding", fail_count,
                 expected_intervals.size());
        if (fail_count == 0 && expected_intervals.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
